@@ hw/rtl/vspa_pkg.sv @@
package vspa_pkg;

    localparam int ENT_SLOTS = 64;
    localparam int IDX_W = 6;
    localparam int GEN_W = 16;
    localparam int COMP_TYPES = 4;
    localparam int TYPE_W = 2;
    localparam int LIMIT_W = 7;
    localparam int POOL_SLOTS = 64;

    localparam int LINK_W = IDX_W + 1;
    localparam int ROW_W = COMP_TYPES * LINK_W;

    localparam int CHUNK_W = 16;
    localparam int CHUNKS = POOL_SLOTS / CHUNK_W;
    localparam int CHUNK_SEL_W = $clog2(CHUNKS);
    localparam int CHUNK_BIT_W = $clog2(CHUNK_W);

    localparam int IN_DATA_W = 32;
    localparam int OUT_DATA_W = 32;

    localparam logic [1:0] CMD_SPAWN = 2'd0;
    localparam logic [1:0] CMD_DESTROY = 2'd1;
    localparam logic [1:0] CMD_ADD = 2'd2;
    localparam logic [1:0] CMD_LOOKUP = 2'd3;

    localparam logic [2:0] ST_OK = 3'd0;
    localparam logic [2:0] ST_FULL = 3'd1;
    localparam logic [2:0] ST_STALE = 3'd2;
    localparam logic [2:0] ST_PRESENT = 3'd3;
    localparam logic [2:0] ST_ABSENT = 3'd4;

    typedef struct packed {
        logic                     start;
        logic [POOL_SLOTS-1:0]    free_map;
    } scan_req_t;

    typedef struct packed {
        logic                     done;
        logic                     found;
        logic [IDX_W-1:0]         index;
    } scan_rsp_t;

endpackage

@@ hw/rtl/vspa_scan.sv @@
module vspa_scan
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  vspa_pkg::scan_req_t   req,
    output vspa_pkg::scan_rsp_t   rsp
);

    logic [vspa_pkg::POOL_SLOTS-1:0]  free_reg;
    logic [vspa_pkg::CHUNK_SEL_W-1:0] chunk_reg;
    logic                             busy_reg;
    logic [vspa_pkg::CHUNK_W-1:0]     chunk_bits;
    logic [vspa_pkg::CHUNK_BIT_W-1:0] low_bit;
    logic                             any_bit;
    logic                             last_chunk;

    assign chunk_bits = free_reg[chunk_reg * vspa_pkg::CHUNK_W +: vspa_pkg::CHUNK_W];
    assign any_bit = |chunk_bits;
    assign last_chunk = (chunk_reg == vspa_pkg::CHUNK_SEL_W'(vspa_pkg::CHUNKS - 1));

    always_comb
    begin
        low_bit = '0;
        for (int i = vspa_pkg::CHUNK_W - 1; i >= 0; i--)
        begin
            if (chunk_bits[i])
            begin
                low_bit = vspa_pkg::CHUNK_BIT_W'(i);
            end
        end
    end

    always_comb
    begin
        rsp.done = busy_reg && (any_bit || last_chunk);
        rsp.found = any_bit;
        rsp.index = {chunk_reg, low_bit};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            chunk_reg <= '0;
        end
        else if (req.start)
        begin
            busy_reg <= 1'b1;
            chunk_reg <= '0;
        end
        else if (busy_reg)
        begin
            if (any_bit || last_chunk)
            begin
                busy_reg <= 1'b0;
            end
            else
            begin
                chunk_reg <= chunk_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            free_reg <= req.free_map;
        end
    end

endmodule

@@ hw/rtl/versioned_slot_and_pool_allocator_unit.sv @@
// Generational handle allocator. One command is taken at a time; s_tready is high only
// while the sequencer is idle. Destroy and look up pass from acceptance to the result
// register through table read, execute and output. Spawn, and add component on a live
// handle whose type is not yet present, also pass through the shared free-slot scanner,
// which examines sixteen bitmap bits per cycle. The sequencer is idle again once the
// result is registered, so the next command can be accepted in the following cycle at
// the earliest. A new command is accepted while the previous result still waits on the
// master side.
module versioned_slot_and_pool_allocator_unit
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // command[1:0], ent_index[7:2], ent_version[23:8], comp_type[25:24], zero pad.
    input  logic [31:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // status[2:0], out_index[8:3], out_version[24:9], comp_slot[30:25], zero pad.
    output logic [31:0] m_tdata,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [6:0]  cfg_data
);

    localparam int IDX_W = vspa_pkg::IDX_W;
    localparam int GEN_W = vspa_pkg::GEN_W;
    localparam int LINK_W = vspa_pkg::LINK_W;
    localparam int ROW_W = vspa_pkg::ROW_W;
    localparam int TYPES = vspa_pkg::COMP_TYPES;
    localparam int SLOTS = vspa_pkg::ENT_SLOTS;
    localparam int POOL = vspa_pkg::POOL_SLOTS;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN_ENT,
        S_RD,
        S_EXEC,
        S_SCAN_POOL,
        S_DONE
    } state_t;

    state_t state_reg;

    logic [1:0]                  cmd_reg;
    logic [IDX_W-1:0]            idx_reg;
    logic [GEN_W-1:0]            ver_reg;
    logic [vspa_pkg::TYPE_W-1:0] type_reg;

    logic [2:0]                  res_status_reg;
    logic [IDX_W-1:0]            res_index_reg;
    logic [GEN_W-1:0]            res_version_reg;
    logic [IDX_W-1:0]            res_slot_reg;

    logic                        m_tvalid_reg;
    logic [31:0]                 m_tdata_reg;

    logic [SLOTS-1:0]            live_reg;
    logic [SLOTS-1:0]            gen_valid_reg;
    logic [POOL-1:0]             pool_busy_reg [TYPES];
    logic [vspa_pkg::LIMIT_W-1:0] limit_reg [TYPES];

    logic [GEN_W-1:0]            gen_mem [SLOTS];
    logic [ROW_W-1:0]            link_mem [SLOTS];
    logic [GEN_W-1:0]            gen_q_reg;
    logic [ROW_W-1:0]            link_q_reg;

    logic                        gen_we;
    logic [GEN_W-1:0]            gen_wdata;
    logic                        link_we;
    logic [ROW_W-1:0]            link_wdata;

    logic [GEN_W-1:0]            gen_cur;
    logic [GEN_W-1:0]            gen_inc;
    logic                        handle_live;
    logic [LINK_W-1:0]           link_sel;
    logic [POOL-1:0]             limit_mask;
    logic [vspa_pkg::LIMIT_W-1:0] limit_sel;

    vspa_pkg::scan_req_t         scan_req;
    vspa_pkg::scan_rsp_t         scan_rsp;

    vspa_scan u_scan
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (scan_req),
        .rsp   (scan_rsp)
    );

    assign s_tready = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata = m_tdata_reg;

    assign gen_cur = gen_valid_reg[idx_reg] ? gen_q_reg : '0;
    assign gen_inc = gen_cur + 1'b1;
    assign handle_live = live_reg[idx_reg] && (gen_cur == ver_reg);
    assign link_sel = link_q_reg[type_reg * LINK_W +: LINK_W];
    assign limit_sel = limit_reg[type_reg];

    always_comb
    begin
        for (int i = 0; i < POOL; i++)
        begin
            limit_mask[i] = (vspa_pkg::LIMIT_W'(i) < limit_sel);
        end
    end

    always_comb
    begin
        scan_req.start = 1'b0;
        scan_req.free_map = ~live_reg;
        if (state_reg == S_IDLE && s_tvalid && s_tdata[1:0] == vspa_pkg::CMD_SPAWN)
        begin
            scan_req.start = 1'b1;
        end
        else if (state_reg == S_EXEC && cmd_reg == vspa_pkg::CMD_ADD && handle_live
                 && !link_sel[LINK_W-1])
        begin
            scan_req.start = 1'b1;
            scan_req.free_map = ~pool_busy_reg[type_reg] & limit_mask;
        end
    end

    always_comb
    begin
        gen_we = 1'b0;
        gen_wdata = gen_inc;
        link_we = 1'b0;
        link_wdata = '0;
        if (state_reg == S_EXEC)
        begin
            if (cmd_reg == vspa_pkg::CMD_SPAWN)
            begin
                gen_we = 1'b1;
                link_we = 1'b1;
            end
            else if (cmd_reg == vspa_pkg::CMD_DESTROY && handle_live)
            begin
                link_we = 1'b1;
            end
        end
        else if (state_reg == S_SCAN_POOL && scan_rsp.done && scan_rsp.found)
        begin
            link_we = 1'b1;
            link_wdata = link_q_reg;
            link_wdata[type_reg * LINK_W +: LINK_W] = {1'b1, scan_rsp.index};
        end
    end

    always_ff @(posedge clk)
    begin
        if (gen_we)
        begin
            gen_mem[idx_reg] <= gen_wdata;
        end
        if (link_we)
        begin
            link_mem[idx_reg] <= link_wdata;
        end
        gen_q_reg <= gen_mem[idx_reg];
        link_q_reg <= link_mem[idx_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            m_tvalid_reg <= 1'b0;
            live_reg <= '0;
            gen_valid_reg <= '0;
            for (int t = 0; t < TYPES; t++)
            begin
                pool_busy_reg[t] <= '0;
                limit_reg[t] <= vspa_pkg::LIMIT_W'(POOL);
            end
        end
        else
        begin
            if (cfg_valid)
            begin
                limit_reg[cfg_index] <= cfg_data;
            end
            if (m_tvalid_reg && m_tready && state_reg != S_DONE)
            begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (s_tvalid)
                    begin
                        cmd_reg <= s_tdata[1:0];
                        idx_reg <= s_tdata[7:2];
                        ver_reg <= s_tdata[23:8];
                        type_reg <= s_tdata[25:24];
                        res_index_reg <= s_tdata[7:2];
                        res_version_reg <= s_tdata[23:8];
                        res_slot_reg <= '0;
                        res_status_reg <= vspa_pkg::ST_OK;
                        if (s_tdata[1:0] == vspa_pkg::CMD_SPAWN)
                        begin
                            state_reg <= S_SCAN_ENT;
                        end
                        else
                        begin
                            state_reg <= S_RD;
                        end
                    end
                end
                S_SCAN_ENT:
                begin
                    if (scan_rsp.done)
                    begin
                        if (scan_rsp.found)
                        begin
                            idx_reg <= scan_rsp.index;
                            state_reg <= S_RD;
                        end
                        else
                        begin
                            res_status_reg <= vspa_pkg::ST_FULL;
                            res_index_reg <= '0;
                            res_version_reg <= '0;
                            state_reg <= S_DONE;
                        end
                    end
                end
                S_RD:
                begin
                    state_reg <= S_EXEC;
                end
                S_EXEC:
                begin
                    state_reg <= S_DONE;
                    if (cmd_reg == vspa_pkg::CMD_SPAWN)
                    begin
                        live_reg[idx_reg] <= 1'b1;
                        gen_valid_reg[idx_reg] <= 1'b1;
                        res_index_reg <= idx_reg;
                        res_version_reg <= gen_inc;
                    end
                    else if (!handle_live)
                    begin
                        res_status_reg <= vspa_pkg::ST_STALE;
                    end
                    else if (cmd_reg == vspa_pkg::CMD_DESTROY)
                    begin
                        live_reg[idx_reg] <= 1'b0;
                        for (int t = 0; t < TYPES; t++)
                        begin
                            if (link_q_reg[t * LINK_W + LINK_W - 1])
                            begin
                                pool_busy_reg[t][link_q_reg[t * LINK_W +: IDX_W]] <= 1'b0;
                            end
                        end
                    end
                    else if (cmd_reg == vspa_pkg::CMD_ADD)
                    begin
                        if (link_sel[LINK_W-1])
                        begin
                            res_status_reg <= vspa_pkg::ST_PRESENT;
                            res_slot_reg <= link_sel[IDX_W-1:0];
                        end
                        else
                        begin
                            state_reg <= S_SCAN_POOL;
                        end
                    end
                    else
                    begin
                        if (link_sel[LINK_W-1])
                        begin
                            res_slot_reg <= link_sel[IDX_W-1:0];
                        end
                        else
                        begin
                            res_status_reg <= vspa_pkg::ST_ABSENT;
                        end
                    end
                end
                S_SCAN_POOL:
                begin
                    if (scan_rsp.done)
                    begin
                        state_reg <= S_DONE;
                        if (scan_rsp.found)
                        begin
                            pool_busy_reg[type_reg][scan_rsp.index] <= 1'b1;
                            res_slot_reg <= scan_rsp.index;
                        end
                        else
                        begin
                            res_status_reg <= vspa_pkg::ST_FULL;
                        end
                    end
                end
                S_DONE:
                begin
                    if (!m_tvalid_reg || m_tready)
                    begin
                        m_tvalid_reg <= 1'b1;
                        m_tdata_reg <= {1'b0, res_slot_reg, res_version_reg,
                                        res_index_reg, res_status_reg};
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule
